// File: sv/ddd_pkg.sv
// Shared types, widths and calendar constants for the day difference block.
package ddd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DistW  = 22;

  // Day count from 1 January of year 1 reaches about 6.0e6 for year 16383.
  localparam int unsigned CountW = 23;

  // Quarter of a year value, and the quotient of that by 25.
  localparam int unsigned QuarterW = YearW - 2;
  localparam int unsigned Div25W   = 8;

  // floor(x / 25) = (x * Recip25) >> Recip25Shift for x < 2**QuarterW.
  localparam int unsigned Recip25Shift = 16;
  localparam int unsigned Recip25W     = 12;
  localparam logic [Recip25W-1:0] Recip25 = Recip25W'(2622);
  localparam int unsigned ProdW = QuarterW + Recip25W;

  localparam logic [8:0] DaysPerYear = 9'd365;
  localparam logic [4:0] Century4    = 5'd25;
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);

  localparam int unsigned MonOffW = 9;
  localparam int unsigned MonDayW = 10;

  // Days before each month of a common year; months past December add 31.
  localparam logic [MonOffW-1:0] DaysBeforeMonth [16] = '{
    9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd396, 9'd427
  };

  // Stage loads that the top level hands to each lane.
  typedef struct packed {
    logic load_a;
    logic load_b;
  } lane_load_t;

endpackage

// File: sv/ddd_lane.sv
// One lane: turns a calendar date into its day count in two pipeline stages.
module ddd_lane
  import ddd_pkg::*;
(
  input  logic                clk_i,
  input  lane_load_t          load_i,
  input  logic [DayW-1:0]     day_i,
  input  logic [MonthW-1:0]   month_i,
  input  logic [YearW-1:0]    year_i,
  output logic [CountW-1:0]   count_o
);

  logic [YearW-1:0]    prev_year;
  logic [QuarterW-1:0] prev_quarter;
  logic [QuarterW-1:0] year_quarter;

  logic [CountW-1:0]   year_days_d, year_days_q;
  logic [QuarterW-1:0] prev_quarter_q;
  logic [ProdW-1:0]    prod_prev_d, prod_prev_q;
  logic [ProdW-1:0]    prod_year_d, prod_year_q;
  logic [QuarterW-1:0] year_quarter_q;
  logic                year_mod4_d, year_mod4_q;
  logic                past_feb_d, past_feb_q;
  logic [MonDayW-1:0]  mon_day_d, mon_day_q;

  logic [Div25W-1:0]   prev_div100;
  logic [Div25W-1:0]   year_div100;
  logic [Div25W+4:0]   year_back;
  logic                year_mod100;
  logic                leap;
  logic [CountW-1:0]   count_d, count_q;

  // Stage A: year days, reciprocal products for the century terms, and the month and day offset.
  always_comb begin
    prev_year    = (year_i == '0) ? '0 : year_i - YearW'(1);
    prev_quarter = prev_year[YearW-1:2];
    year_quarter = year_i[YearW-1:2];
    year_days_d  = CountW'(prev_year) * CountW'(DaysPerYear);
    prod_prev_d  = ProdW'(prev_quarter) * ProdW'(Recip25);
    prod_year_d  = ProdW'(year_quarter) * ProdW'(Recip25);
    year_mod4_d  = (year_i[1:0] == 2'b00);
    past_feb_d   = (month_i > MonthFeb);
    mon_day_d    = MonDayW'(DaysBeforeMonth[month_i]) + MonDayW'(day_i);
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load_a) begin
      year_days_q    <= year_days_d;
      prev_quarter_q <= prev_quarter;
      prod_prev_q    <= prod_prev_d;
      prod_year_q    <= prod_year_d;
      year_quarter_q <= year_quarter;
      year_mod4_q    <= year_mod4_d;
      past_feb_q     <= past_feb_d;
      mon_day_q      <= mon_day_d;
    end
  end

  // Stage B: leap test and the final sum.
  always_comb begin
    prev_div100 = prod_prev_q[Recip25Shift +: Div25W];
    year_div100 = prod_year_q[Recip25Shift +: Div25W];
    year_back   = (Div25W+5)'(year_div100) * (Div25W+5)'(Century4);
    year_mod100 = year_mod4_q && (year_back == (Div25W+5)'(year_quarter_q));
    leap        = year_mod4_q && (!year_mod100 || (year_div100[1:0] == 2'b00));
    count_d     = year_days_q
                + CountW'(prev_quarter_q)
                - CountW'(prev_div100)
                + CountW'(prev_div100[Div25W-1:2])
                + CountW'(mon_day_q)
                + CountW'(past_feb_q && leap);
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load_b) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// File: sv/ddd_merge.sv
// Merge stage: absolute difference of the two lane counts, saturated.
module ddd_merge
  import ddd_pkg::*;
(
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [CountW-1:0] count_a_i,
  input  logic [CountW-1:0] count_b_i,
  output logic [DistW-1:0]  dist_o
);

  logic [CountW-1:0] diff;
  logic [DistW-1:0]  dist_d, dist_q;

  always_comb begin
    diff = (count_a_i > count_b_i) ? count_a_i - count_b_i : count_b_i - count_a_i;
    // clamp anything past the output range
    dist_d = (diff[CountW-1:DistW] != '0) ? '1 : diff[DistW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

// File: sv/date_day_difference.sv
// Top level of the Gregorian day difference block.
// Each request carries two dates (day, month, year) and yields one result: the
// absolute number of days between them, clamped to the 22-bit output range.
// One request is taken every clock cycle while in_stall_o is low; a result is
// registered in turn by the two stages of each date lane (reciprocal
// multiply, then the day sum) and by the registered merge stage. Each stage
// holds its request while the one after it is full and stalled, so bubbles
// are squeezed out during a stall.
module date_day_difference
  import ddd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DayW-1:0]   first_day_i,
  input  logic [MonthW-1:0] first_month_i,
  input  logic [YearW-1:0]  first_year_i,
  input  logic [DayW-1:0]   second_day_i,
  input  logic [MonthW-1:0] second_month_i,
  input  logic [YearW-1:0]  second_year_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DistW-1:0]  day_distance_o
);

  logic       valid_a_q, valid_b_q, valid_c_q;
  logic       adv_a, adv_b, adv_c;
  lane_load_t lane_load;

  logic [CountW-1:0] count_first;
  logic [CountW-1:0] count_second;

  // Advance a stage when it is empty or the stage after it moves.
  assign adv_c = !valid_c_q || !out_stall_i;
  assign adv_b = !valid_b_q || adv_c;
  assign adv_a = !valid_a_q || adv_b;

  assign lane_load.load_a = adv_a && in_valid_i;
  assign lane_load.load_b = adv_b && valid_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      if (adv_a) valid_a_q <= in_valid_i;
      if (adv_b) valid_b_q <= valid_a_q;
      if (adv_c) valid_c_q <= valid_b_q;
    end
  end

  ddd_lane u_lane_first (
    .clk_i   (clk_i),
    .load_i  (lane_load),
    .day_i   (first_day_i),
    .month_i (first_month_i),
    .year_i  (first_year_i),
    .count_o (count_first)
  );

  ddd_lane u_lane_second (
    .clk_i   (clk_i),
    .load_i  (lane_load),
    .day_i   (second_day_i),
    .month_i (second_month_i),
    .year_i  (second_year_i),
    .count_o (count_second)
  );

  ddd_merge u_merge (
    .clk_i     (clk_i),
    .load_i    (adv_c && valid_b_q),
    .count_a_i (count_first),
    .count_b_i (count_second),
    .dist_o    (day_distance_o)
  );

  assign in_stall_o  = !adv_a;
  assign out_valid_o = valid_c_q;

endmodule

// File: sv/ddd_checker.sv
// Port-level checks for the day difference block, bound to the top level.
module ddd_checker
  import ddd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [DayW-1:0]   first_day_i,
  input logic [MonthW-1:0] first_month_i,
  input logic [YearW-1:0]  first_year_i,
  input logic [DayW-1:0]   second_day_i,
  input logic [MonthW-1:0] second_month_i,
  input logic [YearW-1:0]  second_year_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DistW-1:0]  day_distance_o
);

  logic in_take;
  logic same_date;

  assign in_take   = in_valid_i && !in_stall_o;
  assign same_date = (first_day_i == second_day_i) && (first_month_i == second_month_i)
                  && (first_year_i == second_year_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(day_distance_o))
    else $error("stalled result changed or dropped");

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage is empty");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("request did not reach the output in three cycles");

  a_same_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && same_date ##1 !out_stall_i ##1 !out_stall_i |=> day_distance_o == '0)
    else $error("equal dates gave a nonzero distance");

endmodule

bind date_day_difference ddd_checker u_ddd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .first_day_i    (first_day_i),
  .first_month_i  (first_month_i),
  .first_year_i   (first_year_i),
  .second_day_i   (second_day_i),
  .second_month_i (second_month_i),
  .second_year_i  (second_year_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .day_distance_o (day_distance_o)
);
